// File: sv/puri_pkg.sv
// Shared types and constants for the URI percent encoder.
package puri_pkg;

  localparam int CHAR_W = 8;

  // Encoding mode register codes; the unused code behaves as MODE_UNRES
  typedef enum logic [1:0] {
    MODE_UNRES = 2'd0,
    MODE_HOST  = 2'd1,
    MODE_PATH  = 2'd2
  } mode_t;

  localparam logic [CHAR_W-1:0] PCT_CHAR = 8'h25;  // '%'
  localparam logic [CHAR_W-1:0] NUL_CHAR = 8'h00;

  // Results planned for one input word
  typedef struct packed {
    logic [1:0]        cnt;       // number of results: 0, 1 or 3
    logic              has_char;
    logic              err;
    logic              eos;       // string ends with this word
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c1;
    logic [CHAR_W-1:0] c2;
  } plan_t;

endpackage

// File: sv/puri_class.sv
// Byte classifier: mode and error state, plans the results of one word.
module puri_class
  import puri_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_last,
  input  logic              accept,
  output plan_t             plan
);

  localparam logic [CHAR_W-1:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  logic [1:0] mode_r;
  logic       error_seen_r;
  logic       error_seen_nxt;
  logic       unres;
  logic       subd;
  logic       keep;
  logic       is_nul;

  // Mode register and dropped-string flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_UNRES;
      error_seen_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (accept) begin
        error_seen_r <= error_seen_nxt;
      end
    end
  end

  // Character classes (ASCII only; high bytes match nothing)
  always_comb begin
    // alnum, '-', '.', '_', '~'
    unres = in_char inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                            8'h2D, 8'h2E, 8'h5F, 8'h7E};
    // ! $ & ' ( ) * + , ; =
    subd  = in_char inside {8'h21, 8'h24, [8'h26:8'h2C], 8'h3B, 8'h3D};
    case (mode_r)
      MODE_HOST: begin
        // hex digits are already alnum; add ':' '[' ']'
        keep = unres || subd || (in_char inside {8'h3A, 8'h5B, 8'h5D});
      end
      MODE_PATH: begin
        // ':' '@' '/'
        keep = unres || subd || (in_char inside {8'h3A, 8'h40, 8'h2F});
      end
      default: begin
        keep = unres;
      end
    endcase
  end

  assign is_nul = (in_char == NUL_CHAR);

  // Result plan and next error state
  always_comb begin
    plan           = '0;
    error_seen_nxt = error_seen_r;
    if (error_seen_r) begin
      // dropping the rest of a bad string; close it on its last byte
      plan.err = 1'b1;
      plan.eos = 1'b1;
      plan.cnt = in_last ? 2'd1 : 2'd0;
      if (in_last) begin
        error_seen_nxt = 1'b0;
      end
    end else if (is_nul) begin
      plan.cnt = 2'd1;
      plan.err = 1'b1;
      plan.eos = in_last;
      error_seen_nxt = !in_last;
    end else if (keep) begin
      plan.cnt      = 2'd1;
      plan.has_char = 1'b1;
      plan.eos      = in_last;
      plan.c0       = in_char;
    end else begin
      plan.cnt      = 2'd3;
      plan.has_char = 1'b1;
      plan.eos      = in_last;
      plan.c0       = PCT_CHAR;
      plan.c1       = HEX_DIGITS[in_char[7:4]];
      plan.c2       = HEX_DIGITS[in_char[3:0]];
    end
  end

endmodule

// File: sv/puri_emit.sv
// Result sequencer: holds one planned word and issues its results into an output register.
module puri_emit
  import puri_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  plan_t             plan,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_has_char,
  output logic              out_last_run,
  output logic              out_eos,
  output logic              out_err
);

  logic              hold_v_r;
  logic              hold_v_nxt;
  plan_t             plan_r;
  logic [1:0]        step_r;
  logic [1:0]        step_nxt;
  logic              out_v_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_has_r;
  logic              out_lrun_r;
  logic              out_eos_r;
  logic              out_err_r;
  logic              out_load;
  logic              last_step;
  logic              hold_done;
  logic              accept;
  logic [CHAR_W-1:0] cur_char;

  assign out_load  = !out_v_r || out_ready;
  assign last_step = (step_r == plan_r.cnt - 2'd1);
  assign hold_done = hold_v_r && out_load && last_step;
  assign in_ready  = !hold_v_r || hold_done;
  assign accept    = in_valid && in_ready;

  // Character for the current step
  always_comb begin
    case (step_r)
      2'd0:    cur_char = plan_r.c0;
      2'd1:    cur_char = plan_r.c1;
      default: cur_char = plan_r.c2;
    endcase
  end

  // Hold stage next state
  always_comb begin
    hold_v_nxt = hold_v_r;
    step_nxt   = step_r;
    if (hold_v_r && out_load) begin
      step_nxt = step_r + 2'd1;
    end
    if (hold_done) begin
      hold_v_nxt = 1'b0;
    end
    if (accept && plan.cnt != 2'd0) begin
      hold_v_nxt = 1'b1;
      step_nxt   = 2'd0;
    end
  end

  // Hold stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      step_r   <= 2'd0;
    end else begin
      hold_v_r <= hold_v_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plan_r <= plan;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= hold_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && hold_v_r) begin
      out_char_r <= cur_char;
      out_has_r  <= plan_r.has_char;
      out_lrun_r <= last_step;
      out_eos_r  <= last_step && plan_r.eos;
      out_err_r  <= plan_r.err;
    end
  end

  assign out_valid    = out_v_r;
  assign out_char     = out_char_r;
  assign out_has_char = out_has_r;
  assign out_last_run = out_lrun_r;
  assign out_eos      = out_eos_r;
  assign out_err      = out_err_r;

endmodule

// File: sv/percent_encoder_uri.sv
// Top level of the URI percent encoder.
//
// channel   dir  tdata                tuser                              tlast
// in_       in   [7:0] in_char        -                                  last_in_string
// out_      out  [7:0] out_char       [0] has_char [1] last_of_run [2] error  end_of_string
// cfg_      in   cfg_wdata[1:0] = encode_mode, written when cfg_we is high
//
// A kept byte gives one result, an encoded byte three (one result per cycle out of
// the output register unless stalled); a dropped byte gives none unless it ends the string.
// An input word passes the hold stage and the output register before its first result.
// Reset (rst_n low, synchronous) clears the mode to 0 and the error state.
// A stalled output holds its word; the hold stage accepts when empty or on its last result.
module percent_encoder_uri
  import puri_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,   // encode_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_char
  input  logic        in_tlast,    // last_in_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_char
  output logic [2:0]  out_tuser,   // [0] has_char, [1] last_of_run, [2] error
  output logic        out_tlast    // end_of_string
);

  plan_t plan;
  logic  in_accept;

  assign in_accept = in_tvalid && in_tready;

  // Classification and result planning
  puri_class u_class (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .accept    (in_accept),
    .plan      (plan)
  );

  // Result sequencing
  puri_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .plan         (plan),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_char     (out_tdata),
    .out_has_char (out_tuser[0]),
    .out_last_run (out_tuser[1]),
    .out_eos      (out_tlast),
    .out_err      (out_tuser[2])
  );

endmodule

// File: sv/puri_chk.sv
// Port-level checker for the URI percent encoder, bound to the top level.
module puri_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // String end only on the last result of a word
  a_eos_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1])
    else $error("end of string without end of run");

  // Error words carry no character and close their run
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> !out_tuser[0] && out_tuser[1] && out_tdata == 8'h00)
    else $error("malformed error word");

  // A '%' is followed by a word of the same run that is not its last
  a_pct_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[0] && out_tdata == 8'h25 && !out_tuser[1]
    |=> !out_tvalid || !out_tuser[1])
    else $error("escape sequence ended early");

endmodule

bind percent_encoder_uri puri_chk u_puri_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: verif/percent_encoder_uri_test.sv
// Self-checking testbench for the URI percent encoder: streams strings, predicts every word.
module percent_encoder_uri_test
  import puri_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Unused mode code, must behave as MODE_UNRES
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // Cycles to let the block settle before a mode write and at the end
  localparam int DRAIN_CYC = 8;
  // Cycles without any handshake before the run is declared hung
  localparam int QUIET_LIMIT = 2000;

  // One source byte with its end-of-string flag
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } src_word_t;

  // One encoded output word
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       run_end;
    logic       eos;
    logic       err;
  } enc_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;   // [7:0] in_char
  logic       in_tlast = 1'b0; // last_in_string
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;       // [7:0] out_char
  logic [2:0] out_tuser;       // [0] has_char, [1] last_of_run, [2] error
  logic       out_tlast;       // end_of_string

  src_word_t  src_q[$];
  enc_word_t  enc_q[$];
  int         words_left = 0;
  int         fail_cnt = 0;
  int         quiet_cnt = 0;
  int         send_gap = 0;
  int         stall_cnt = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  logic       in_taken = 1'b0;
  logic [1:0] mode_cur = MODE_UNRES;
  logic       drop_rest = 1'b0;

  percent_encoder_uri dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Character classes of RFC 3986, ASCII only
  function automatic bit keep_char(input logic [7:0] c, input logic [1:0] m);
    bit alnum;
    bit unres;
    bit subd;
    alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    unres = alnum || c inside {"-", "_", ".", "~"};
    subd  = c inside {"!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "="};
    case (m)
      MODE_HOST: return unres || subd || c inside {":", "[", "]"};
      MODE_PATH: return unres || subd || c inside {":", "@", "/"};
      default:   return unres;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'("0" + nib) : 8'("A" + nib - 4'd10);
  endfunction

  // Expected output words for one accepted source byte
  function automatic void encode_byte(input logic [7:0] c, input logic last);
    if (drop_rest) begin
      // rest of a string with a NUL: only its end gives the closing error word
      if (last) begin
        drop_rest = 1'b0;
        enc_q.push_back('{NUL_CHAR, 1'b0, 1'b1, 1'b1, 1'b1});
      end
    end else if (c == NUL_CHAR) begin
      drop_rest = !last;
      enc_q.push_back('{NUL_CHAR, 1'b0, 1'b1, last, 1'b1});
    end else if (keep_char(c, mode_cur)) begin
      enc_q.push_back('{c, 1'b1, 1'b1, last, 1'b0});
    end else begin
      enc_q.push_back('{PCT_CHAR, 1'b1, 1'b0, 1'b0, 1'b0});
      enc_q.push_back('{hex_char(c[7:4]), 1'b1, 1'b0, 1'b0, 1'b0});
      enc_q.push_back('{hex_char(c[3:0]), 1'b1, 1'b1, last, 1'b0});
    end
  endfunction

  // Source driver: one word per handshake, random gaps between words
  always @(negedge clk) begin
    src_word_t w;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (src_q.size() > 0) begin
        w = src_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= w.ch;
        in_tlast  <= w.last;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
          send_gap <= $urandom_range(1, 19);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Sink ready: random stall bursts
  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt  <= stall_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        stall_cnt <= $urandom_range(1, 19);
    end
  end

  // Monitor: predict on input handshakes, check on output handshakes
  always @(posedge clk) begin
    enc_word_t e;
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        encode_byte(in_tdata, in_tlast);
        words_left--;
      end
      if (out_tvalid && out_tready) begin
        if (enc_q.size() == 0) begin
          $error("unexpected word: out_char %h tuser %b tlast %b",
                 out_tdata, out_tuser, out_tlast);
          fail_cnt++;
        end else begin
          e = enc_q.pop_front();
          if (out_tdata !== e.ch) begin
            $error("out_char: expected %h, got %h", e.ch, out_tdata);
            fail_cnt++;
          end
          if (out_tuser[0] !== e.has) begin
            $error("has_char: expected %b, got %b", e.has, out_tuser[0]);
            fail_cnt++;
          end
          if (out_tuser[1] !== e.run_end) begin
            $error("last_of_run: expected %b, got %b", e.run_end, out_tuser[1]);
            fail_cnt++;
          end
          if (out_tuser[2] !== e.err) begin
            $error("error: expected %b, got %b", e.err, out_tuser[2]);
            fail_cnt++;
          end
          if (out_tlast !== e.eos) begin
            $error("end_of_string: expected %b, got %b", e.eos, out_tlast);
            fail_cnt++;
          end
        end
      end
    end
    // watchdog on handshake activity
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic push_word(input logic [7:0] c, input logic last);
    src_q.push_back('{c, last});
    words_left++;
  endtask

  // Whole string, end flag on its final byte
  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_word(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return NUL_CHAR;
    if (r < 16) return 8'($urandom_range(128, 255));
    if (r < 70) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(1, 255));
  endfunction

  // Random strings of 1 to 8 bytes until about n bytes give results
  task automatic push_random(input int n);
    int cnt;
    int len;
    bit dead;
    logic [7:0] c;
    cnt = 0;
    while (cnt < n) begin
      len  = $urandom_range(1, 8);
      dead = 1'b0;
      for (int i = 0; i < len; i++) begin
        c = rand_char();
        push_word(c, i == len - 1);
        if (!dead || i == len - 1) cnt++;
        if (c == NUL_CHAR) dead = 1'b1;
      end
    end
  endtask

  task automatic wait_drained();
    while (words_left != 0 || enc_q.size() != 0) @(negedge clk);
  endtask

  // Mode write only once the pipe is empty and settled
  task automatic set_mode(input logic [1:0] m);
    wait_drained();
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mode_cur  = m;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset mode: unreserved only
    gap_pct   = 20;
    stall_pct = 15;
    push_text("Az09-~");
    push_word(8'h20, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'h7F, 1'b1);
    // NUL mid-string: rest dropped, closing error on last byte
    push_word("a", 1'b0);
    push_word(NUL_CHAR, 1'b0);
    push_word("b", 1'b0);
    push_word("%", 1'b1);
    // NUL as the final byte
    push_word(NUL_CHAR, 1'b1);
    push_random(35);

    set_mode(MODE_HOST);
    gap_pct   = 35;
    stall_pct = 30;
    push_text(":[]!@/g");
    push_random(45);

    // a stretch without idling
    set_mode(MODE_PATH);
    gap_pct   = 0;
    stall_pct = 0;
    push_text("/@:[?#");
    push_random(45);

    set_mode(MODE_SPARE);
    gap_pct   = 15;
    stall_pct = 25;
    push_text(".:/x");
    push_random(45);

    // closing part at full rate
    set_mode(MODE_UNRES);
    gap_pct   = 0;
    stall_pct = 0;
    push_random(45);

    wait_drained();
    repeat (DRAIN_CYC) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
